### sv/billboard_facing_angles_defines.svh
// ----------------------------------------------------------------------------
// billboard_facing_angles_defines
// Assertion macros shared by the billboard facing block.
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_FACING_ANGLES_DEFINES_SVH
`define BILLBOARD_FACING_ANGLES_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define BFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication checked outside reset.
`define BFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Constants, types and the arctangent table for the billboard facing block.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned AngW        = 26;
  // Vector width inside the CORDIC: |v| <= 2^33 scaled by 2^24, with growth.
  localparam int unsigned VecW        = 62;
  localparam int unsigned ZW          = 26;

  localparam logic signed [ZW-1:0] Deg90  = ZW'(5898240);
  localparam logic signed [ZW-1:0] Deg180 = ZW'(11796480);

  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [VecW-1:0] vec_t;

  // Per-lane CORDIC state.
  typedef struct packed {
    vec_t             x;
    vec_t             y;
    logic signed [ZW-1:0] z;
    logic             fixed;   // answer already known (y on axis)
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = ZW'(2949120);   1: r = ZW'(1740967);  2: r = ZW'(919879);
      3: r = ZW'(466945);    4: r = ZW'(234379);   5: r = ZW'(117304);
      6: r = ZW'(58666);     7: r = ZW'(29335);    8: r = ZW'(14668);
      9: r = ZW'(7334);      10: r = ZW'(3667);    11: r = ZW'(1833);
      12: r = ZW'(917);      13: r = ZW'(458);     14: r = ZW'(229);
      15: r = ZW'(115);      16: r = ZW'(57);      17: r = ZW'(29);
      18: r = ZW'(14);       19: r = ZW'(7);       20: r = ZW'(4);
      21: r = ZW'(2);        22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Saturate a 34-bit difference to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh07FFFFFFF)       r = 32'sh7FFFFFFF;
    else if (v < -34'sh080000000) r = 32'sh80000000;
    else                          r = v[31:0];
    return r;
  endfunction

  // Prerotation and scaling ahead of the iterations (y, x up to 34 bits).
  function automatic cordic_t cordic_init(input logic signed [33:0] y,
                                          input logic signed [33:0] x);
    cordic_t c;
    logic signed [33:0] nx;
    logic signed [33:0] ny;
    c.fixed = 1'b0;
    c.z     = '0;
    nx      = x;
    ny      = y;
    if (y == '0) begin
      c.fixed = 1'b1;
      c.z     = (x < 0) ? Deg180 : '0;
    end else if (x < 0) begin
      if (y > 0) begin
        nx = y;  ny = -x; c.z = Deg90;
      end else begin
        nx = -y; ny = x;  c.z = -Deg90;
      end
    end
    c.x = {{(VecW-58){nx[33]}}, nx, 24'd0};
    c.y = {{(VecW-58){ny[33]}}, ny, 24'd0};
    return c;
  endfunction

endpackage

### sv/bfa_cordic_stage.sv
// ----------------------------------------------------------------------------
// bfa_cordic_stage
// Registered vectoring CORDIC iterations for both lanes of an item.
// ----------------------------------------------------------------------------
module bfa_cordic_stage (
  input  logic              clk_i,
  input  logic              en_i,
  input  bfa_pkg::cordic_t  a_i,
  input  bfa_pkg::cordic_t  b_i,
  output bfa_pkg::cordic_t  a_o,
  output bfa_pkg::cordic_t  b_o
);
  import bfa_pkg::*;

  cordic_t a_q [CordicSteps];
  cordic_t b_q [CordicSteps];

  function automatic cordic_t iter(input cordic_t c, input int unsigned step);
    cordic_t r;
    r = c;
    if (!c.fixed) begin
      if (c.y >= 0) begin
        r.x = c.x + (c.y >>> step);
        r.y = c.y - (c.x >>> step);
        r.z = c.z + atan_tab(step);
      end else begin
        r.x = c.x - (c.y >>> step);
        r.y = c.y + (c.x >>> step);
        r.z = c.z - atan_tab(step);
      end
    end
    return r;
  endfunction

  // one register per iteration; the shift amount is fixed for each stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0] <= iter(a_i, 0);
      b_q[0] <= iter(b_i, 0);
      for (int unsigned i = 1; i < CordicSteps; i++) begin
        a_q[i] <= iter(a_q[i-1], i);
        b_q[i] <= iter(b_q[i-1], i);
      end
    end
  end

  assign a_o = a_q[CordicSteps-1];
  assign b_o = b_q[CordicSteps-1];

endmodule

### sv/billboard_facing_angles.sv
// Input beats pass a difference stage and a CORDIC init stage, then the CORDIC
// stages and the output register. Throughput: one beat per cycle while the output
// is not stalled; one unrolled CORDIC stage per iteration, both angles in parallel lanes.
// A stall freezes the whole pipeline; an empty slot at the output lets it move.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// billboard_facing_angles
// Turns a billboard toward the camera: atan2 by a pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
module billboard_facing_angles (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic        [30:0]  height_i,
  input  logic signed [31:0]  cam_x_i,
  input  logic signed [31:0]  cam_y_i,
  input  logic signed [31:0]  cam_z_i,
  input  logic                face_x_i,
  input  logic                face_y_i,
  input  bfa_pkg::ang_t       old_rot_y_i,
  input  bfa_pkg::ang_t       old_rot_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bfa_pkg::ang_t       rot_y_o,
  output bfa_pkg::ang_t       rot_z_o
);
  import bfa_pkg::*;
  `include "billboard_facing_angles_defines.svh"

  localparam int unsigned NStg = CordicSteps + 2;

  typedef struct packed {
    logic fx;
    logic fy;
    ang_t oy;
    ang_t oz;
  } side_t;

  logic              en;
  logic [NStg-1:0]   vld_q;
  side_t             side_q [NStg];

  // stage 0: differences
  logic signed [31:0] dx_q, dy_q, dz_q;
  // stage 1: CORDIC init
  cordic_t ca_d, cb_d, ca_q, cb_q;
  cordic_t ca_end, cb_end;
  logic signed [33:0] ax, az;

  ang_t ry_d, rz_d, ry_q, rz_q;
  logic out_v_q;

  // Pipeline moves whenever the output slot is free or being taken.
  assign en         = !out_v_q || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[NStg-2:0], in_valid_i};
      out_v_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= sat32(34'(pos_x_i) - 34'(cam_x_i));
      dy_q <= sat32(34'(pos_y_i) + 34'({3'b0, height_i[30:1]}) - 34'(cam_y_i));
      dz_q <= sat32(34'(pos_z_i) - 34'(cam_z_i));
      side_q[0] <= '{fx: face_x_i, fy: face_y_i, oy: old_rot_y_i, oz: old_rot_z_i};
      for (int i = 1; i < NStg; i++) side_q[i] <= side_q[i-1];
      ca_q <= ca_d;
      cb_q <= cb_d;
      ry_q <= ry_d;
      rz_q <= rz_d;
    end
  end

  assign ax   = (dx_q < 0) ? -34'(dx_q) : 34'(dx_q);
  assign az   = (dz_q < 0) ? -34'(dz_q) : 34'(dz_q);
  assign ca_d = cordic_init(34'(dy_q), ax + az);
  assign cb_d = cordic_init(34'(dz_q), 34'(dx_q));

  bfa_cordic_stage u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ca_q),
    .b_i   (cb_q),
    .a_o   (ca_end),
    .b_o   (cb_end)
  );

  always_comb begin
    side_t s;
    s = side_q[NStg-1];
    if (s.fx || s.fy) begin
      rz_d = s.fx ? ca_end.z : '0;
      ry_d = s.fy ? (-cb_end.z - Deg90) : '0;
    end else begin
      rz_d = s.oz;
      ry_d = s.oy;
    end
  end

  assign out_valid_o = out_v_q;
  assign rot_y_o     = ry_q;
  assign rot_z_o     = rz_q;

  `BFA_ASSERT_NEXT(a_hold_out, out_v_q && out_stall_i, out_v_q && $stable(ry_q))
  `BFA_ASSERT_IMP(a_stall_only_full, in_stall_o, out_v_q)
  `BFA_ASSERT_NEXT(a_advance, en && vld_q[NStg-1], out_v_q)

endmodule

### test/tb_billboard_facing_angles.sv
// ----------------------------------------------------------------------------
// tb_billboard_facing_angles
// Streams billboard/camera beats through the block with random gaps and
// stalls, predicts both rotation angles with an independent CORDIC model and
// compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_billboard_facing_angles;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Steps     = 20;
  localparam int Latency   = 23;
  localparam int IdleLimit = 20000;
  localparam longint Q90   = 64'sd5898240;
  localparam longint Q180  = 64'sd11796480;

  typedef struct packed {
    logic signed [25:0] ry;
    logic signed [25:0] rz;
  } angles_t;

  typedef struct {
    logic signed [31:0] px, py, pz, cx, cy, cz;
    logic [30:0]        h;
    logic               fx, fy;
    logic signed [25:0] ory, orz;
  } billboard_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i, cam_x_i, cam_y_i, cam_z_i;
  logic [30:0] height_i;
  logic face_x_i, face_y_i;
  bfa_pkg::ang_t old_rot_y_i, old_rot_z_i, rot_y_o, rot_z_o;

  angles_t pending_angles[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_off = 0;
  bit  no_gaps = 0;

  billboard_facing_angles uut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint arsh(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint atan_q16(int i);
    longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                      29, 14, 7, 4, 2, 1};
    return (i < 23) ? t[i] : 0;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (y == 0) return (x < 0) ? Q180 : 0;
    if (x < 0) begin
      if (y > 0) begin
        t = x; x = y; y = -t; z = Q90;
      end else begin
        t = x; x = -y; y = t; z = -Q90;
      end
    end
    x = x * 64'sd16777216;
    y = y * 64'sd16777216;
    for (int i = 0; i < Steps; i++) begin
      xs = arsh(x, i);
      ys = arsh(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_q16(i);
      end else begin
        x = x - ys; y = y + xs; z -= atan_q16(i);
      end
    end
    return z;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic angles_t facing_angles(billboard_t b);
    angles_t a;
    longint dx, dy, dz, ax, az;
    if (!(b.fx || b.fy)) begin
      a.ry = b.ory;
      a.rz = b.orz;
      return a;
    end
    dx = clamp32(longint'(b.px) - longint'(b.cx));
    dy = clamp32(longint'(b.py) + longint'(b.h >> 1) - longint'(b.cy));
    dz = clamp32(longint'(b.pz) - longint'(b.cz));
    ax = dx < 0 ? -dx : dx;
    az = dz < 0 ? -dz : dz;
    a.rz = b.fx ? 26'(vector_angle(dy, ax + az)) : '0;
    a.ry = b.fy ? 26'(-vector_angle(dz, dx) - Q90) : '0;
    return a;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF - $urandom_range(3);
      1: return 32'h80000000 + $urandom_range(3);
      2: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [25:0] rand_angle();
    return 26'($urandom_range(47185920) - 23592960);
  endfunction

  task automatic send_billboard(billboard_t b);
    if (!no_gaps && $urandom_range(9) < 3)
      repeat ($urandom_range(9) == 0 ? $urandom_range(40, 10) : $urandom_range(3, 1))
        @(negedge clk_i);
    pos_x_i = b.px; pos_y_i = b.py; pos_z_i = b.pz;
    cam_x_i = b.cx; cam_y_i = b.cy; cam_z_i = b.cz;
    height_i = b.h; face_x_i = b.fx; face_y_i = b.fy;
    old_rot_y_i = b.ory; old_rot_z_i = b.orz;
    in_valid_i = 1;
    do @(posedge clk_i); while (in_stall_o);
    pending_angles.push_back(facing_angles(b));
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  function automatic billboard_t random_billboard();
    billboard_t b;
    b.px = rand_coord(); b.py = rand_coord(); b.pz = rand_coord();
    b.cx = rand_coord(); b.cy = rand_coord(); b.cz = rand_coord();
    b.h = ($urandom_range(3) == 0) ? 31'(32'h7FFFFFFF - $urandom_range(1))
                                   : 31'($urandom);
    b.fx = 1'($urandom_range(1));
    b.fy = 1'($urandom_range(1));
    b.ory = rand_angle();
    b.orz = rand_angle();
    return b;
  endfunction

  task automatic test_directed();
    billboard_t b;
    b = '{default: '0};
    b.fx = 1; b.fy = 1;
    send_billboard(b);                      // zero vector
    b.px = 32'sd65536; send_billboard(b);   // on +x axis
    b.px = -32'sd65536; send_billboard(b);  // on -x axis
    b.px = 0; b.pz = 32'sd65536; send_billboard(b);
    b.pz = -32'sd65536; send_billboard(b);
    b.pz = 0; b.h = 31'h7FFFFFFF; send_billboard(b);
    // saturating differences at both ends
    b.px = 32'h7FFFFFFF; b.cx = 32'h80000000; b.pz = 32'h80000000;
    b.cz = 32'h7FFFFFFF; b.py = 32'h7FFFFFFF; b.cy = 32'h80000000;
    send_billboard(b);
    b.px = 32'h80000000; b.cx = 32'h7FFFFFFF; b.py = 32'h80000000;
    b.cy = 32'h7FFFFFFF; b.h = 0; send_billboard(b);
    b.fy = 0; send_billboard(b);
    b.fx = 0; b.fy = 1; send_billboard(b);
    // pass-through of the old rotation at the angle extremes
    b.fy = 0; b.ory = 26'sd23592960; b.orz = -26'sd23592960; send_billboard(b);
    b.ory = -26'sd23592960; b.orz = 26'sd23592960; send_billboard(b);
    b.ory = '1; b.orz = '0; send_billboard(b);
    for (int i = 0; i < 8; i++) begin
      b = '{default: '0};
      b.fx = i[0]; b.fy = 1;
      b.px = (i & 2) ? -32'sd100 : 32'sd100;
      b.pz = (i & 4) ? -32'sd300 : 32'sd300;
      send_billboard(b);
    end
  endtask

  task automatic test_random_stream();
    repeat (420) send_billboard(random_billboard());
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    no_gaps = 1;
    fork
      repeat (60) send_billboard(random_billboard());
      begin
        repeat (80) @(posedge clk_i);
        hold_off = 0;
      end
    join
    no_gaps = 0;
  endtask

  // receiver stall: random gaps, a long hold-off on request
  initial begin
    out_stall_i = 1;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_stall_i = 1;
      else if ($urandom_range(9) < 2) out_stall_i = 1;
      else out_stall_i = 0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    angles_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_angles.size() == 0) begin
        $display("%0t: result beat with nothing expected: rot_y=%0d rot_z=%0d",
                 $time, rot_y_o, rot_z_o);
        errors++;
      end else begin
        want = pending_angles.pop_front();
        if (rot_y_o !== want.ry) begin
          $display("%0t: rot_y expected %0d actual %0d", $time, want.ry, rot_y_o);
          errors++;
        end
        if (rot_z_o !== want.rz) begin
          $display("%0t: rot_z expected %0d actual %0d", $time, want.rz, rot_z_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("billboard_facing_angles verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 0;
    in_valid_i = 0;
    pos_x_i = 0; pos_y_i = 0; pos_z_i = 0; height_i = 0;
    cam_x_i = 0; cam_y_i = 0; cam_z_i = 0;
    face_x_i = 0; face_y_i = 0; old_rot_y_i = 0; old_rot_z_i = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    test_directed();
    test_backpressure();
    test_random_stream();
    wait (pending_angles.size() == 0);
    repeat (Latency * 4) @(posedge clk_i);
    if (errors == 0 && pending_angles.size() == 0)
      $display("billboard_facing_angles verification clean");
    else
      $display("billboard_facing_angles verification failed");
    $finish;
  end
endmodule
